// File: sv/spe_pkg.sv
// Shared types, codes and constants for the stepper step-pulse engine.
// No dependencies; used by spe_pacer, spe_stepper and stepper_step_pulse_engine.
package spe_pkg;

  localparam int PERIOD_W   = 20;
  localparam int POS_W      = 32;
  localparam int TIME_W     = 64;
  localparam int ELAPSED_W  = 32;
  localparam int COIL_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 40;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd25000;

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_TO_TARGET = 2'd1,
    MODE_FREE      = 2'd2
  } mode_t;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_LOAD   = 1'b1
  } op_t;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 2'd3;

  typedef struct packed {
    logic             fire;
    logic             load;
    logic             due;
    logic [POS_W-1:0] new_position;
  } step_req_t;

  function automatic logic [COIL_W-1:0] coil_of(input logic [1:0] phase);
    logic [COIL_W-1:0] coil;
    case (phase)
      2'd0:    coil = 4'd10;
      2'd1:    coil = 4'd6;
      2'd2:    coil = 4'd5;
      default: coil = 4'd9;
    endcase
    return coil;
  endfunction

endpackage

// File: sv/stepper_step_pulse_engine.sv
// Channel  Dir  Bits  Contents (lowest bit first)
// s_*      in   96+1  tdata: sample_time[63:0], new_position[95:64]; tuser: operation
// m_*      out  40    tdata: stepped[0], coil_drive[4:1], position[36:5], zero pad
// cfg_*    in   2+32  cfg_index selects the register, cfg_data is the value
//
// One item per cycle while m_* is not stalled; each request passes through the input
// register and its result is registered onto m_*. The pacing compare, position
// compare and 64-bit time add all close between those two registers.
// Synchronous active-high reset clears timing, position and coils and restores config defaults.
// A stalled result holds the pipe; the input register refills when it drains.
// Top level of the stepper step-pulse engine; depends on spe_pkg, spe_pacer, spe_stepper.
module stepper_step_pulse_engine (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [spe_pkg::IN_DATA_W-1:0]     s_tdata,  // sample_time, new_position
  input  logic                              s_tuser,  // operation
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [spe_pkg::OUT_DATA_W-1:0]    m_tdata,  // stepped, coil_drive, position
  input  logic                              cfg_we,
  input  logic [spe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [spe_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [spe_pkg::PERIOD_W-1:0] pulse_period;
  logic [1:0]                   drive_mode;
  logic                         spin_direction;
  logic [spe_pkg::POS_W-1:0]    target_position;

  logic                         in_valid;
  logic                         in_op;
  logic [spe_pkg::TIME_W-1:0]   in_time;
  logic [spe_pkg::POS_W-1:0]    in_position;
  logic                         fire;
  logic                         due;
  spe_pkg::step_req_t           req;

  logic                         stepped_next;
  logic [spe_pkg::COIL_W-1:0]   coil_next;
  logic [spe_pkg::POS_W-1:0]    position_next;

  logic                         out_stepped;
  logic [spe_pkg::COIL_W-1:0]   out_coil;
  logic [spe_pkg::POS_W-1:0]    out_position;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_period    <= spe_pkg::PERIOD_RESET;
      drive_mode      <= spe_pkg::MODE_IDLE;
      spin_direction  <= 1'b0;
      target_position <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        spe_pkg::REG_PERIOD:    pulse_period    <= cfg_data[spe_pkg::PERIOD_W-1:0];
        spe_pkg::REG_MODE:      drive_mode      <= cfg_data[1:0];
        spe_pkg::REG_DIRECTION: spin_direction  <= cfg_data[0];
        spe_pkg::REG_TARGET:    target_position <= cfg_data[spe_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op       <= s_tuser;
      in_time     <= s_tdata[spe_pkg::TIME_W-1:0];
      in_position <= s_tdata[spe_pkg::TIME_W +: spe_pkg::POS_W];
    end
  end

  spe_pacer u_pacer (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .op           (in_op),
    .sample_time  (in_time),
    .pulse_period (pulse_period),
    .due          (due)
  );

  always_comb begin
    req.fire         = fire;
    req.load         = (in_op == spe_pkg::OP_LOAD);
    req.due          = due;
    req.new_position = in_position;
  end

  spe_stepper u_stepper (
    .clk             (clk),
    .rst             (rst),
    .req             (req),
    .drive_mode      (drive_mode),
    .spin_direction  (spin_direction),
    .target_position (target_position),
    .stepped_next    (stepped_next),
    .coil_next       (coil_next),
    .position_next   (position_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_stepped  <= stepped_next;
      out_coil     <= coil_next;
      out_position <= position_next;
    end
  end

  assign m_tdata = {3'b000, out_position, out_coil, out_stepped};

endmodule

// File: sv/spe_pacer.sv
// Pulse pacing: holds the last-pulse time and flags a due pulse per sample.
// Depends on spe_pkg.
module spe_pacer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic                          op,
  input  logic [spe_pkg::TIME_W-1:0]    sample_time,
  input  logic [spe_pkg::PERIOD_W-1:0]  pulse_period,
  output logic                          due
);

  logic [spe_pkg::TIME_W-1:0]    last_pulse_time;
  logic [spe_pkg::TIME_W-1:0]    last_pulse_time_next;
  logic [spe_pkg::ELAPSED_W-1:0] elapsed;
  logic [spe_pkg::ELAPSED_W-1:0] period_ext;
  logic [spe_pkg::ELAPSED_W-1:0] lateness;
  logic [spe_pkg::ELAPSED_W-1:0] half_period;

  always_comb begin
    period_ext  = {{(spe_pkg::ELAPSED_W-spe_pkg::PERIOD_W){1'b0}}, pulse_period};
    half_period = period_ext >> 1;
    elapsed     = sample_time[spe_pkg::ELAPSED_W-1:0]
                - last_pulse_time[spe_pkg::ELAPSED_W-1:0];
    lateness    = elapsed - period_ext;
    due         = (op == spe_pkg::OP_SAMPLE) && (elapsed >= period_ext);
    if (lateness < half_period) begin
      last_pulse_time_next = last_pulse_time
        + {{(spe_pkg::TIME_W-spe_pkg::PERIOD_W){1'b0}}, pulse_period};
    end else begin
      last_pulse_time_next = sample_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_pulse_time <= '0;
    end else if (fire && due) begin
      last_pulse_time <= last_pulse_time_next;
    end
  end

endmodule

// File: sv/spe_stepper.sv
// Step decision and motor state: phase index, position and coil pattern.
// Depends on spe_pkg.
module spe_stepper (
  input  logic                          clk,
  input  logic                          rst,
  input  spe_pkg::step_req_t            req,
  input  logic [1:0]                    drive_mode,
  input  logic                          spin_direction,
  input  logic [spe_pkg::POS_W-1:0]     target_position,
  output logic                          stepped_next,
  output logic [spe_pkg::COIL_W-1:0]    coil_next,
  output logic [spe_pkg::POS_W-1:0]     position_next
);

  logic [1:0]                 phase_index;
  logic [1:0]                 phase_index_next;
  logic [spe_pkg::POS_W-1:0]  step_count;
  logic [spe_pkg::COIL_W-1:0] coil_pattern;
  logic                       fwd;
  logic                       back;

  always_comb begin
    fwd  = 1'b0;
    back = 1'b0;
    case (drive_mode)
      spe_pkg::MODE_FREE: begin
        fwd  = !spin_direction;
        back = spin_direction;
      end
      spe_pkg::MODE_TO_TARGET: begin
        fwd  = $signed(target_position) > $signed(step_count);
        back = $signed(target_position) < $signed(step_count);
      end
      default: begin
        fwd  = 1'b0;
        back = 1'b0;
      end
    endcase

    stepped_next     = 1'b0;
    phase_index_next = phase_index;
    position_next    = step_count;
    coil_next        = coil_pattern;
    if (req.load) begin
      position_next = req.new_position;
    end else if (req.due && fwd) begin
      stepped_next     = 1'b1;
      phase_index_next = phase_index + 2'd1;
      position_next    = step_count + 32'd1;
      coil_next        = spe_pkg::coil_of(phase_index_next);
    end else if (req.due && back) begin
      stepped_next     = 1'b1;
      phase_index_next = phase_index - 2'd1;
      position_next    = step_count - 32'd1;
      coil_next        = spe_pkg::coil_of(phase_index_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_index  <= '0;
      step_count   <= '0;
      coil_pattern <= '0;
    end else if (req.fire) begin
      phase_index  <= phase_index_next;
      step_count   <= position_next;
      coil_pattern <= coil_next;
    end
  end

endmodule

// File: tb/sv/tb_stepper_step_pulse_engine.sv
// Self-checking testbench for stepper_step_pulse_engine: drives time samples and
// position loads, predicts pacing, stepping and coil drive, and checks each result.
// Depends on spe_pkg and the stepper_step_pulse_engine RTL.
module tb_stepper_step_pulse_engine;

  localparam logic [1:0]  MODE_SPARE  = 2'd3;
  localparam logic [15:0] PHASE_COILS = 16'h956A;
  localparam int unsigned HOLD_CYCLES = 150;

  typedef struct packed {
    spe_pkg::op_t op;
    logic [63:0]  now;
    logic [31:0]  new_pos;
  } motion_req_t;

  typedef struct packed {
    logic        stepped;
    logic [3:0]  coils;
    logic [31:0] position;
  } drive_state_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [spe_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic                           s_tuser = 1'b0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [spe_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                           cfg_we = 1'b0;
  logic [spe_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [spe_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  stepper_step_pulse_engine dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // predicted block state and register copies
  logic [63:0] last_pulse = '0;
  logic [1:0]  phase = '0;
  logic [31:0] position = '0;
  logic [3:0]  coils = '0;
  logic [19:0] period_cfg = spe_pkg::PERIOD_RESET;
  logic [1:0]  mode_cfg = spe_pkg::MODE_IDLE;
  logic        dir_cfg = 1'b0;
  logic [31:0] target_cfg = '0;

  motion_req_t  pending[$];
  drive_state_t expected_drive[$];
  int unsigned  queued = 0;
  int unsigned  accepted = 0;
  int unsigned  results_seen = 0;
  int unsigned  errors = 0;
  logic         req_taken = 1'b0;
  logic         idle_on = 1'b0;
  logic         hold_done = 1'b0;
  int unsigned  gap_left = 0;
  int unsigned  stall_left = 0;
  int unsigned  hold_left = 0;

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic drive_state_t advance_motor(input motion_req_t req);
    drive_state_t res;
    logic [31:0]  elapsed;
    logic [31:0]  late;
    logic         step_up;
    logic         step_dn;
    step_up = 1'b0;
    step_dn = 1'b0;
    if (req.op == spe_pkg::OP_LOAD) begin
      position = req.new_pos;
    end else begin
      elapsed = 32'(req.now - last_pulse);
      if (elapsed >= {12'd0, period_cfg}) begin
        late = elapsed - {12'd0, period_cfg};
        if (late < {13'd0, period_cfg[19:1]}) begin
          last_pulse = last_pulse + {44'd0, period_cfg};
        end else begin
          last_pulse = req.now;
        end
        if (mode_cfg == spe_pkg::MODE_FREE) begin
          step_up = !dir_cfg;
          step_dn = dir_cfg;
        end else if (mode_cfg == spe_pkg::MODE_TO_TARGET) begin
          step_up = $signed(target_cfg) > $signed(position);
          step_dn = $signed(target_cfg) < $signed(position);
        end
      end
    end
    if (step_up) begin
      phase = phase + 2'd1;
      position = position + 32'd1;
    end
    if (step_dn) begin
      phase = phase - 2'd1;
      position = position - 32'd1;
    end
    if (step_up || step_dn) begin
      coils = PHASE_COILS[phase*4 +: 4];
    end
    res.stepped = step_up || step_dn;
    res.coils = coils;
    res.position = position;
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 40) $display("mismatch at result %0d: %s", results_seen, msg);
  endtask

  task automatic add_sample(input logic [63:0] now);
    motion_req_t req;
    req.op = spe_pkg::OP_SAMPLE;
    req.now = now;
    req.new_pos = $urandom;
    pending.push_back(req);
    queued++;
  endtask

  task automatic add_load(input logic [31:0] new_pos);
    motion_req_t req;
    req.op = spe_pkg::OP_LOAD;
    req.now = {$urandom, $urandom};
    req.new_pos = new_pos;
    pending.push_back(req);
    queued++;
  endtask

  task automatic write_reg(input logic [spe_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      spe_pkg::REG_PERIOD:    period_cfg = value[19:0];
      spe_pkg::REG_MODE:      mode_cfg = value[1:0];
      spe_pkg::REG_DIRECTION: dir_cfg = value[0];
      default:                target_cfg = value;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    while (accepted != queued || expected_drive.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_taken) begin
      if (gap_left > 0) begin
        s_tvalid <= 1'b0;
        gap_left--;
      end else if (pending.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata <= {pending[0].new_pos, pending[0].now};
        s_tuser <= pending[0].op;
        void'(pending.pop_front());
        gap_left = pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (!hold_done && results_seen >= 200 && pending.size() > 40) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    drive_state_t want;
    motion_req_t  req;
    if (rst) begin
      req_taken = 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_drive.size() == 0) begin
          report_mismatch("result with no request waiting");
        end else begin
          want = expected_drive.pop_front();
          if (m_tdata[0] !== want.stepped)
            report_mismatch($sformatf("stepped %b, want %b", m_tdata[0], want.stepped));
          if (m_tdata[4:1] !== want.coils)
            report_mismatch($sformatf("coil_drive %h, want %h", m_tdata[4:1], want.coils));
          if (m_tdata[36:5] !== want.position)
            report_mismatch($sformatf("position %h, want %h", m_tdata[36:5], want.position));
        end
      end
      req_taken = s_tvalid && s_tready;
      if (req_taken) begin
        req.op = spe_pkg::op_t'(s_tuser);
        req.now = s_tdata[63:0];
        req.new_pos = s_tdata[95:64];
        expected_drive.push_back(advance_motor(req));
        accepted++;
      end
    end
  end

  initial begin
    logic [63:0] t;
    logic [31:0] tgt;
    logic [19:0] pv;
    int unsigned r;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    add_sample(64'd0);
    add_sample(64'd25000);
    add_sample('1);
    add_load(32'h7FFF_FFFF);
    settle();
    write_reg(spe_pkg::REG_MODE, 32'(spe_pkg::MODE_FREE));
    write_reg(spe_pkg::REG_PERIOD, 32'd1);
    add_sample(64'd0);
    add_sample(64'd1);
    settle();
    write_reg(spe_pkg::REG_DIRECTION, 32'd1);
    add_load(32'h8000_0000);
    add_sample(64'd2);
    settle();
    write_reg(spe_pkg::REG_PERIOD, 32'd0);
    add_sample(64'd2);
    add_sample(64'd2);
    settle();
    write_reg(spe_pkg::REG_PERIOD, 32'd1000000);
    write_reg(spe_pkg::REG_MODE, 32'(MODE_SPARE));
    add_sample(64'd1000002);
    settle();
    write_reg(spe_pkg::REG_PERIOD, 32'd4);
    write_reg(spe_pkg::REG_MODE, 32'(spe_pkg::MODE_TO_TARGET));
    write_reg(spe_pkg::REG_TARGET, 32'hFFFF_FFFB);
    add_load(32'd5);
    add_sample(64'd1000006);
    add_sample(64'd1000011);
    add_sample(64'd1000020);
    add_sample(64'd1000021);
    settle();
    write_reg(spe_pkg::REG_TARGET, 32'h7FFF_FFFF);
    add_load(32'h8000_0000);
    add_sample(64'd1000030);
    add_load(32'h7FFF_FFFF);
    add_sample(64'd1000040);
    settle();

    t = 64'd1000040;
    for (int ph = 0; ph < 8; ph++) begin
      idle_on = (ph % 3 != 0);
      r = $urandom_range(0, 9);
      if (r == 0) pv = 20'd0;
      else if (r == 1) pv = 20'd1;
      else if (r == 2) pv = 20'hFFFFF;
      else if (r == 3) pv = 20'd1000000;
      else if (r < 7) pv = 20'($urandom_range(2, 12));
      else pv = 20'($urandom_range(13, 5000));
      write_reg(spe_pkg::REG_PERIOD, {12'd0, pv});
      r = $urandom_range(0, 9);
      if (r == 0) write_reg(spe_pkg::REG_MODE, 32'(spe_pkg::MODE_IDLE));
      else if (r == 1) write_reg(spe_pkg::REG_MODE, 32'(MODE_SPARE));
      else if (r < 6) write_reg(spe_pkg::REG_MODE, 32'(spe_pkg::MODE_TO_TARGET));
      else write_reg(spe_pkg::REG_MODE, 32'(spe_pkg::MODE_FREE));
      write_reg(spe_pkg::REG_DIRECTION, 32'($urandom_range(0, 1)));
      r = $urandom_range(0, 9);
      if (r < 6) tgt = position + 32'($urandom_range(0, 80)) - 32'd40;
      else if (r == 6) tgt = 32'h7FFF_FFFF;
      else if (r == 7) tgt = 32'h8000_0000;
      else tgt = $urandom;
      write_reg(spe_pkg::REG_TARGET, tgt);
      if ($urandom_range(0, 3) == 0) t = {$urandom, $urandom};
      for (int n = 0; n < 100; n++) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          add_load($urandom);
        end else if (r < 8) begin
          add_load(target_cfg + 32'($urandom_range(0, 20)) - 32'd10);
        end else begin
          if (r < 55) t = t + {44'd0, period_cfg} + 64'($urandom_range(0, period_cfg));
          else if (r < 75) t = t + 64'($urandom_range(0, period_cfg));
          else if (r < 85) t = t + 64'($urandom);
          else if (r >= 95) t = {$urandom, $urandom};
          add_sample(t);
        end
      end
      settle();
    end

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
